/* rtl/grid_bfs_next_step_macros.svh */
// Assertion macros used by the checker file gbfs_check.
`ifndef GRID_BFS_NEXT_STEP_MACROS_SVH
`define GRID_BFS_NEXT_STEP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GBFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GBFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/gbfs_pkg.sv */
// ----------------------------------------------------------------------------
// gbfs_pkg
// Field widths, direction codes, parent marks, op codes and register indices of the grid path engine.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  localparam int ColW  = 5;
  localparam int RowW  = 4;
  localparam int WallW = 32;
  localparam int DirW  = 2;
  localparam int MarkW = 3;

  typedef enum logic [DirW-1:0] {
    DIR_PC = 2'd0,
    DIR_PR = 2'd1,
    DIR_NC = 2'd2,
    DIR_NR = 2'd3
  } dir_t;

  localparam logic [MarkW-1:0] MARK_UNVISITED = 3'd7;
  localparam logic [MarkW-1:0] MARK_START     = 3'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;

endpackage

/* rtl/grid_bfs_next_step.sv */
// ----------------------------------------------------------------------------
// grid_bfs_next_step
// Breadth-first next-step engine on a 4-connected wall grid.
// ----------------------------------------------------------------------------
// A load beat writes one wall row. A query beat clears the parent memory (one
// entry a cycle), then pops each cell from the queue memory (read, then capture)
// and tests its four neighbours (one off the grid is skipped, else parent and
// wall read, then write back), then walks parents from the target back (parent
// read, then check). A start off the grid or equal to the target answers with
// no step and no search. One item is worked on at a time.
module grid_bfs_next_step import gbfs_pkg::*; #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // row_index[3:0], row_walls[35:4], from_col[40:36], from_row[44:41],
  // to_col[49:45], to_row[53:50], zero pad[55:54]
  input  logic [55:0] s_tdata,
  // op[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // next_col[4:0], next_row[8:5], step_dir[10:9], zero pad[15:11]
  output logic [15:0] m_tdata,
  // step_found[0]
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int Cells = MAX_COLS * MAX_ROWS;
  localparam int CA    = $clog2(Cells);
  localparam int WD    = (MAX_ROWS < 16) ? MAX_ROWS : 16;
  localparam int WA    = $clog2(WD);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SEED, ST_POP, ST_POPW, ST_NBR, ST_NBC,
    ST_WALK_RD, ST_WALK_CHK, ST_DONE
  } state_t;

  state_t state;

  logic [5:0] grid_cols;
  logic [4:0] grid_rows;
  logic [6:0] acols, arows;

  logic [ColW-1:0] from_col, to_col, cur_col, nb_col, walk_col, res_col;
  logic [RowW-1:0] from_row, to_row, cur_row, nb_row, walk_row, res_row;
  logic [DirW-1:0] dir, res_dir;
  logic            res_found;
  logic [CA-1:0]   clr_cnt;
  logic [CA:0]     q_head, q_tail;

  // memories
  logic [MarkW-1:0]     parent_mem [Cells];
  logic [RowW+ColW-1:0] queue_mem  [Cells];
  logic [WallW-1:0]     wall_mem   [WD];
  logic [MarkW-1:0]     parent_q;
  logic [RowW+ColW-1:0] queue_q;
  logic [WallW-1:0]     wall_q;

  logic             p_we, p_re, q_we, w_we, w_re;
  logic [CA-1:0]    p_waddr, p_raddr;
  logic [MarkW-1:0] p_wdata;

  // input fields
  logic [RowW-1:0]  in_row_index;
  logic [WallW-1:0] in_row_walls;
  logic [ColW-1:0]  in_from_col, in_to_col;
  logic [RowW-1:0]  in_from_row, in_to_row;
  assign in_row_index = s_tdata[3:0];
  assign in_row_walls = s_tdata[35:4];
  assign in_from_col  = s_tdata[40:36];
  assign in_from_row  = s_tdata[44:41];
  assign in_to_col    = s_tdata[49:45];
  assign in_to_row    = s_tdata[53:50];

  function automatic logic [CA-1:0] cell_addr(input logic [ColW-1:0] c,
                                              input logic [RowW-1:0] r);
    logic [CA+RowW+ColW:0] a;
    a = (CA+RowW+ColW+1)'(r) * (CA+RowW+ColW+1)'(MAX_COLS)
        + (CA+RowW+ColW+1)'(c);
    return a[CA-1:0];
  endfunction

  assign acols = ({1'b0, grid_cols} > 7'(MAX_COLS)) ? 7'(MAX_COLS) : {1'b0, grid_cols};
  assign arows = ({2'b0, grid_rows} > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : {2'b0, grid_rows};

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  logic in_from_in;
  assign in_from_in = (7'(in_from_col) < acols) && (7'(in_from_row) < arows);

  // neighbour of the current cell in direction dir
  logic [5:0] nc6;
  logic [4:0] nr5;
  logic       nb_ok, nb_in;
  always_comb begin
    nc6   = {1'b0, cur_col};
    nr5   = {1'b0, cur_row};
    nb_ok = 1'b1;
    unique case (dir_t'(dir))
      DIR_PC: nc6 = {1'b0, cur_col} + 6'd1;
      DIR_PR: nr5 = {1'b0, cur_row} + 5'd1;
      DIR_NC: begin
        nc6   = {1'b0, cur_col} - 6'd1;
        nb_ok = (cur_col != '0);
      end
      DIR_NR: begin
        nr5   = {1'b0, cur_row} - 5'd1;
        nb_ok = (cur_row != '0);
      end
      default: nb_ok = 1'b0;
    endcase
    nb_in = nb_ok && (nc6 < 6'd32) && ({1'b0, nc6} < acols) && ({2'b0, nr5} < arows);
  end

  // parent step back from the walk cell
  logic [ColW-1:0] prev_col;
  logic [RowW-1:0] prev_row;
  always_comb begin
    prev_col = walk_col;
    prev_row = walk_row;
    unique case (dir_t'(parent_q[DirW-1:0]))
      DIR_PC: prev_col = walk_col - 5'd1;
      DIR_PR: prev_row = walk_row - 4'd1;
      DIR_NC: prev_col = walk_col + 5'd1;
      DIR_NR: prev_row = walk_row + 4'd1;
      default: prev_col = walk_col;
    endcase
  end

  logic nb_take;
  assign nb_take = !wall_q[nb_col] && (parent_q == MARK_UNVISITED);

  // memory port control
  always_comb begin
    p_we    = 1'b0;
    p_waddr = clr_cnt;
    p_wdata = MARK_UNVISITED;
    p_re    = 1'b0;
    p_raddr = cell_addr(nc6[ColW-1:0], nr5[RowW-1:0]);
    q_we    = 1'b0;
    w_we    = s_acc && (s_tuser == OP_LOAD) && (32'(in_row_index) < 32'(MAX_ROWS));
    w_re    = (state == ST_NBR);
    unique case (state)
      ST_CLEAR: p_we = 1'b1;
      ST_SEED: begin
        p_we    = 1'b1;
        p_waddr = cell_addr(from_col, from_row);
        p_wdata = MARK_START;
        q_we    = 1'b1;
      end
      ST_NBR: p_re = nb_in;
      ST_NBC: begin
        p_we    = nb_take;
        p_waddr = cell_addr(nb_col, nb_row);
        p_wdata = {1'b0, dir};
        q_we    = nb_take;
      end
      ST_WALK_RD: begin
        p_re    = 1'b1;
        p_raddr = cell_addr(walk_col, walk_row);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) parent_mem[p_waddr] <= p_wdata;
    if (p_re) parent_q <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      if (state == ST_SEED) queue_mem[q_tail[CA-1:0]] <= {from_row, from_col};
      else queue_mem[q_tail[CA-1:0]] <= {nb_row, nb_col};
    end
    if (state == ST_POP) queue_q <= queue_mem[q_head[CA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (w_we) wall_mem[in_row_index[WA-1:0]] <= in_row_walls;
    if (w_re) wall_q <= wall_mem[nr5[WA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      grid_cols <= 6'd32;
      grid_rows <= 5'd16;
      m_tvalid  <= 1'b0;
      q_head    <= '0;
      q_tail    <= '0;
      clr_cnt   <= '0;
      dir       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_COLS) grid_cols <= cfg_data;
        else if (cfg_index == REG_ROWS) grid_rows <= cfg_data[4:0];
      end
      if (m_tready && state != ST_DONE) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_acc && (s_tuser == OP_QUERY)) begin
            from_col  <= in_from_col;
            from_row  <= in_from_row;
            to_col    <= in_to_col;
            to_row    <= in_to_row;
            res_found <= 1'b0;
            res_col   <= '0;
            res_row   <= '0;
            res_dir   <= '0;
            clr_cnt   <= '0;
            q_head    <= '0;
            q_tail    <= '0;
            if (!in_from_in || (in_from_col == in_to_col && in_from_row == in_to_row))
              state <= ST_DONE;
            else
              state <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CA'(Cells - 1)) state <= ST_SEED;
        end
        ST_SEED: begin
          q_head <= '0;
          q_tail <= (CA+1)'(1);
          state  <= ST_POP;
        end
        ST_POP: begin
          if (q_head == q_tail) state <= ST_DONE;
          else begin
            q_head <= q_head + 1'b1;
            state  <= ST_POPW;
          end
        end
        ST_POPW: begin
          cur_col <= queue_q[ColW-1:0];
          cur_row <= queue_q[RowW+ColW-1:ColW];
          dir     <= '0;
          state   <= ST_NBR;
        end
        ST_NBR: begin
          nb_col <= nc6[ColW-1:0];
          nb_row <= nr5[RowW-1:0];
          if (nb_in) state <= ST_NBC;
          else if (dir == DIR_NR) state <= ST_POP;
          else dir <= dir + 1'b1;
        end
        ST_NBC: begin
          if (nb_take) begin
            q_tail <= q_tail + 1'b1;
          end
          if (nb_take && nb_col == to_col && nb_row == to_row) begin
            walk_col <= to_col;
            walk_row <= to_row;
            state    <= ST_WALK_RD;
          end else if (dir == DIR_NR) begin
            state <= ST_POP;
          end else begin
            dir   <= dir + 1'b1;
            state <= ST_NBR;
          end
        end
        ST_WALK_RD: state <= ST_WALK_CHK;
        ST_WALK_CHK: begin
          if (prev_col == from_col && prev_row == from_row) begin
            res_found <= 1'b1;
            res_col   <= walk_col;
            res_row   <= walk_row;
            res_dir   <= parent_q[DirW-1:0];
            state     <= ST_DONE;
          end else begin
            walk_col <= prev_col;
            walk_row <= prev_row;
            state    <= ST_WALK_RD;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_found;
            m_tdata  <= {5'd0, res_dir, res_row, res_col};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/gbfs_check.sv */
// ----------------------------------------------------------------------------
// gbfs_check
// Port-level checks for the grid path engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_bfs_next_step_macros.svh"

module gbfs_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [55:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [5:0]  cfg_data
);

  // a stalled result beat holds
  `GBFS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // no step means all result fields zero
  `GBFS_ASSERT_NOW(a_nostep_zero, m_tvalid && !m_tuser, m_tdata == 16'd0)
  // a query beat blocks the input for at least the next cycle
  `GBFS_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && s_tuser, !s_tready)

endmodule

bind grid_bfs_next_step gbfs_check u_gbfs_check (.*);

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and query beats with random idling on both sides, predicts
// each query's first step with a local breadth-first search and compares
// every result beat field by field.
// ----------------------------------------------------------------------------
module testbench import gbfs_pkg::*;;

  localparam int NCOLS = 32;
  localparam int NROWS = 16;
  localparam int NCELLS = NCOLS * NROWS;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic        op;
    logic [3:0]  row_index;
    logic [31:0] row_walls;
    logic [4:0]  from_col;
    logic [3:0]  from_row;
    logic [4:0]  to_col;
    logic [3:0]  to_row;
  } beat_t;

  typedef struct packed {
    logic       found;
    logic [4:0] ncol;
    logic [3:0] nrow;
    logic [1:0] dir;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;

  grid_bfs_next_step u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  beat_t pending_beats[$];
  step_t expected_steps[$];
  logic [31:0] walls_mdl[NROWS];
  int cols_mdl = 32;
  int rows_mdl = 16;
  int mismatches = 0;
  int idle_cycles = 0;
  int no_gaps = 0;
  int beats_sent = 0;
  bit hold_sender = 1'b0;

  function automatic bit on_grid(int c, int r);
    int ac, ar;
    ac = cols_mdl > NCOLS ? NCOLS : cols_mdl;
    ar = rows_mdl > NROWS ? NROWS : rows_mdl;
    return c >= 0 && r >= 0 && c < ac && r < ar;
  endfunction

  function automatic bit is_wall(int c, int r);
    if (!on_grid(c, r) || c >= 32) return 1'b1;
    return walls_mdl[r][c];
  endfunction

  // Model the block's effect of one beat; queries yield one step.
  function automatic void predict_step(beat_t b);
    logic [2:0] mark[NCELLS];
    int qc[NCELLS], qr[NCELLS];
    int head, tail, c, r, d, nc, nr, firstd, guard;
    int dc[4], dr[4];
    bit found;
    step_t s;
    dc = '{1, 0, -1, 0};
    dr = '{0, 1, 0, -1};
    if (b.op == OP_LOAD) begin
      walls_mdl[b.row_index] = b.row_walls;
      return;
    end
    s = '0;
    for (int i = 0; i < NCELLS; i++) mark[i] = MARK_UNVISITED;
    if (!on_grid(b.from_col, b.from_row) ||
        (b.from_col == b.to_col && b.from_row == b.to_row)) begin
      expected_steps.push_back(s);
      return;
    end
    qc[0] = b.from_col; qr[0] = b.from_row;
    head = 0; tail = 1; found = 1'b0;
    mark[b.from_row * NCOLS + b.from_col] = MARK_START;
    while (head < tail && !found) begin
      c = qc[head]; r = qr[head]; head++;
      for (d = 0; d < 4; d++) begin
        nc = c + dc[d]; nr = r + dr[d];
        if (is_wall(nc, nr)) continue;
        if (mark[nr * NCOLS + nc] != MARK_UNVISITED) continue;
        mark[nr * NCOLS + nc] = d[2:0];
        if (tail < NCELLS) begin
          qc[tail] = nc; qr[tail] = nr; tail++;
        end
        if (nc == b.to_col && nr == b.to_row) begin
          found = 1'b1;
          break;
        end
      end
    end
    if (found) begin
      c = b.to_col; r = b.to_row; firstd = -1; guard = 0;
      while (!(c == b.from_col && r == b.from_row) && guard < NCELLS) begin
        guard++;
        d = mark[r * NCOLS + c];
        if (d > 3) begin
          firstd = -1;
          break;
        end
        firstd = d;
        c -= dc[d]; r -= dr[d];
      end
      if (firstd >= 0) begin
        s.found = 1'b1;
        s.ncol = 5'(b.from_col + dc[firstd]);
        s.nrow = 4'(b.from_row + dr[firstd]);
        s.dir = 2'(firstd);
      end
    end
    expected_steps.push_back(s);
  endfunction

  // Driver: model is updated at acceptance so loads and queries stay in order.
  always @(posedge clk) begin
    bit acc;
    acc = s_tvalid && s_tready;
    if (!rst) begin
      if (acc) begin
        predict_step(pending_beats.pop_front());
        beats_sent <= beats_sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_beats.size() > 0 && !hold_sender &&
            (no_gaps > 0 || $urandom_range(99) >= 24)) begin
          s_tvalid <= 1'b1;
          s_tuser <= pending_beats[0].op;
          s_tdata <= {2'b0, pending_beats[0].to_row, pending_beats[0].to_col,
                      pending_beats[0].from_row, pending_beats[0].from_col,
                      pending_beats[0].row_walls, pending_beats[0].row_index};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= (no_gaps > 0 || $urandom_range(99) >= 24);
      if (beats_sent == 120) no_gaps <= 400;
      else if (no_gaps > 0) no_gaps <= no_gaps - 1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    step_t got, want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[4:0], m_tdata[8:5], m_tdata[10:9]};
        if (expected_steps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = expected_steps.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp f=%0d c=%0d r=%0d d=%0d got f=%0d c=%0d r=%0d d=%0d",
                       want.found, want.ncol, want.nrow, want.dir,
                       got.found, got.ncol, got.nrow, got.dir);
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic add_load(int row, logic [31:0] w);
    beat_t b;
    b = '0;
    b.op = OP_LOAD; b.row_index = row[3:0]; b.row_walls = w;
    pending_beats.push_back(b);
  endtask

  task automatic add_query(int fc, int fr, int tc, int tr);
    beat_t b;
    b.op = OP_QUERY; b.row_index = 4'($urandom); b.row_walls = $urandom;
    b.from_col = fc[4:0]; b.from_row = fr[3:0]; b.to_col = tc[4:0]; b.to_row = tr[3:0];
    pending_beats.push_back(b);
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || s_tvalid || expected_steps.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val[5:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_COLS) cols_mdl = val;
    else rows_mdl = val;
  endtask

  // Random walls of low density, so paths usually exist.
  function automatic logic [31:0] sparse_row();
    return $urandom & $urandom & ($urandom_range(1) ? $urandom : 32'hffff_ffff);
  endfunction

  initial begin
    int sizes[6][2];
    sizes = '{'{32, 16}, '{1, 1}, '{2, 2}, '{63, 31}, '{8, 5}, '{17, 9}};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Directed: full grid, all rows open then a few walls.
    for (int r = 0; r < 16; r++) add_load(r, 32'h0);
    add_query(0, 0, 31, 15);
    add_query(31, 15, 0, 0);
    add_query(5, 5, 5, 5);
    add_query(3, 3, 4, 3);
    add_query(3, 3, 3, 4);
    add_query(3, 3, 2, 3);
    add_query(3, 3, 3, 2);
    add_load(7, 32'hffff_ffff);
    add_query(0, 0, 0, 15);
    add_load(7, 32'hffff_fffe);
    add_load(2, 32'h0000_0010);
    add_query(4, 2, 6, 2);
    add_query(0, 0, 4, 2);
    add_query(31, 0, 0, 15);
    drain();
    for (int k = 0; k < 6; k++) begin
      write_reg(REG_COLS, sizes[k][0]);
      write_reg(REG_ROWS, sizes[k][1]);
      for (int r = 0; r < 16; r++) add_load(r, sparse_row());
      add_query(sizes[k][0] > 31 ? 31 : sizes[k][0], 0, 0, 0);
      add_query(0, 0, 31, 15);
      for (int i = 0; i < 16; i++) begin
        if ($urandom_range(7) == 0) add_load($urandom_range(15), sparse_row());
        else if ($urandom_range(3) == 0)
          add_query($urandom_range(31), $urandom_range(15),
                    $urandom_range(31), $urandom_range(15));
        else
          add_query($urandom_range(sizes[k][0] > 32 ? 31 : sizes[k][0] - 1),
                    $urandom_range(sizes[k][1] > 16 ? 15 : sizes[k][1] - 1),
                    $urandom_range(sizes[k][0] > 32 ? 31 : sizes[k][0] - 1),
                    $urandom_range(sizes[k][1] > 16 ? 15 : sizes[k][1] - 1));
      end
      if (k == 2) begin
        // sender pauses until every outstanding result is out
        while (pending_beats.size() > 20) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_steps.size() > 0 || s_tvalid) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end
    if (mismatches == 0 && expected_steps.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
